// File: hw/rtl/wbps_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the weighted backend pool selector.
// No dependencies.
package wbps_pkg;

  localparam int SLOT_COUNT_DEF = 64;
  localparam int RR_W = 64;

  localparam logic [3:0] CMD_ADD     = 4'd0;
  localparam logic [3:0] CMD_REMOVE  = 4'd1;
  localparam logic [3:0] CMD_DRAIN   = 4'd2;
  localparam logic [3:0] CMD_UNDRAIN = 4'd3;
  localparam logic [3:0] CMD_DEAD    = 4'd4;
  localparam logic [3:0] CMD_RESOLVE = 4'd5;
  localparam logic [3:0] CMD_SELECT  = 4'd6;
  localparam logic [3:0] CMD_RELEASE = 4'd7;
  localparam logic [3:0] CMD_QUERY   = 4'd8;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NOT_READY = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_BUSY      = 3'd4;
  localparam logic [2:0] ST_NO_ACTIVE = 3'd5;

  localparam logic [1:0] MODE_RESOLVING = 2'd0;
  localparam logic [1:0] MODE_ACTIVE    = 2'd1;
  localparam logic [1:0] MODE_DRAINING  = 2'd2;
  localparam logic [1:0] MODE_DEAD      = 2'd3;

  typedef struct packed {
    logic        used;
    logic [31:0] ident;
    logic [7:0]  weight;
    logic [1:0]  mode;
    logic        has_address;
    logic [15:0] busy;
  } entry_t;

endpackage

// File: hw/rtl/weighted_backend_pool_selector.sv
`timescale 1ns / 1ps
// Weighted backend pool selector: slot table in one memory, scanned by a sequencer.
// Depends on wbps_pkg.
//
// Commands arrive on the in channel (in_valid/in_ready) and each produces one
// result beat on the out channel (out_valid/out_ready). One command is worked
// on at a time; in_ready is high only while the block is idle.
// Every table command on an enabled pool scans all slots through the single
// memory read port. Select scans twice (once when no slot is active) and in
// between runs a 64-step restoring remainder of the round-robin counter by the
// weight sum. With the pool disabled or an unknown command no slot is scanned
// and the command goes straight to its result.
// After reset the block sweeps the table to zero, one slot a cycle, before
// in_ready rises; configuration writes are taken throughout. The enable register
// is written through cfg_wr_en/cfg_wr_data.
// A result waits in the output register while out_ready is low; a finished
// command holds its table write back until that register is free.
module weighted_backend_pool_selector
  import wbps_pkg::*;
#(
  parameter int SLOT_COUNT = SLOT_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  cmd,
  input  logic [31:0] backend_id,
  input  logic [7:0]  weight,
  input  logic        resolve_ok,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] result_id,
  output logic [5:0]  result_slot,
  output logic [15:0] in_flight_count
);

  localparam int AW  = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW  = $clog2(SLOT_COUNT + 1);
  localparam int TW  = $clog2(SLOT_COUNT * 255 + 1);
  localparam int SLW = (AW > 6) ? AW : 6;
  localparam int DCW = $clog2(RR_W);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_SCAN1, S_DIV, S_SCAN2, S_WRITE
  } state_t;

  state_t            state;
  logic              pool_ready;
  logic [3:0]        cmd_r;
  logic [31:0]       id_r;
  logic [7:0]        weight_r;
  logic              ok_r;
  logic              pool_ok;
  logic [CW-1:0]     cnt;
  logic [AW-1:0]     clr_idx;
  logic              found;
  logic [AW-1:0]     fslot;
  entry_t            fent;
  logic [TW-1:0]     total;
  logic [TW-1:0]     rem;
  logic [RR_W-1:0]   div_sh;
  logic [DCW-1:0]    div_cnt;
  logic [31:0]       next_ident;
  logic [RR_W-1:0]   rr_counter;

  entry_t            mem [SLOT_COUNT];
  entry_t            rdata;
  logic [AW-1:0]     raddr;
  logic              mem_we;
  logic [AW-1:0]     waddr;
  entry_t            wdata;

  logic [CW-1:0]     cnt_m1;
  logic [AW-1:0]     pidx;
  logic              eval;
  logic [7:0]        sw;
  logic              e_active;
  logic [TW:0]       trial;
  logic [TW-1:0]     rem_next;
  logic              out_free;
  logic [2:0]        st_next;
  logic [31:0]       rid_next;
  logic [15:0]       cnt_out_next;
  logic [SLW-1:0]    slot_wide;
  entry_t            upd;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;
  assign cnt_m1   = cnt - 1'b1;
  assign pidx     = cnt_m1[AW-1:0];
  assign eval     = (cnt != '0);
  assign raddr    = cnt[AW-1:0];
  assign sw       = (rdata.weight == 8'd0) ? 8'd1 : rdata.weight;
  assign e_active = rdata.used && (rdata.mode == MODE_ACTIVE);
  assign trial    = {rem, div_sh[RR_W-1]};
  assign rem_next = (trial >= {1'b0, total}) ? TW'(trial - {1'b0, total}) : trial[TW-1:0];
  assign slot_wide = SLW'(fslot);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    upd = fent;
    st_next = ST_OK;
    rid_next = 32'd0;
    cnt_out_next = 16'd0;
    mem_we = 1'b0;
    waddr = fslot;
    wdata = fent;
    if (state == S_CLEAR) begin
      mem_we = 1'b1;
      waddr = clr_idx;
      wdata = '0;
    end else if (!pool_ok) begin
      st_next = ST_NOT_READY;
    end else if (cmd_r == CMD_ADD) begin
      if (!found) begin
        st_next = ST_FULL;
      end else begin
        rid_next = next_ident;
        upd = '0;
        upd.used = 1'b1;
        upd.ident = next_ident;
        upd.weight = (weight_r == 8'd0) ? 8'd1 : weight_r;
        mem_we = 1'b1;
      end
    end else if (cmd_r == CMD_SELECT) begin
      if (!found) begin
        st_next = ST_NO_ACTIVE;
      end else begin
        rid_next = fent.ident;
        if (fent.busy != 16'hFFFF) begin
          upd.busy = fent.busy + 16'd1;
        end
        mem_we = 1'b1;
      end
    end else if (cmd_r <= CMD_QUERY) begin
      if (!found) begin
        st_next = ST_NOT_FOUND;
      end else begin
        mem_we = 1'b1;
        unique case (cmd_r)
          CMD_REMOVE: begin
            if (fent.busy != 16'd0) begin
              st_next = ST_BUSY;
              mem_we = 1'b0;
            end else begin
              upd = '0;
            end
          end
          CMD_DRAIN:   upd.mode = MODE_DRAINING;
          CMD_UNDRAIN: upd.mode = fent.has_address ? MODE_ACTIVE : MODE_RESOLVING;
          CMD_DEAD:    upd.mode = MODE_DEAD;
          CMD_RESOLVE: begin
            if (ok_r) begin
              upd.has_address = 1'b1;
              if (fent.mode == MODE_RESOLVING) begin
                upd.mode = MODE_ACTIVE;
              end
            end else if (fent.mode == MODE_RESOLVING) begin
              upd.mode = MODE_DEAD;
            end
          end
          CMD_RELEASE: begin
            if (fent.busy != 16'd0) begin
              upd.busy = fent.busy - 16'd1;
            end
          end
          default: begin
            cnt_out_next = fent.busy;
            mem_we = 1'b0;
          end
        endcase
      end
    end
    if (state != S_CLEAR) begin
      wdata = upd;
      mem_we = mem_we && (state == S_WRITE) && out_free;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      pool_ready <= 1'b0;
      clr_idx <= '0;
      next_ident <= 32'd1;
      rr_counter <= '0;
      out_valid <= 1'b0;
      cnt <= '0;
    end else begin
      if (cfg_wr_en) begin
        pool_ready <= cfg_wr_data;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == AW'(SLOT_COUNT - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= cmd;
            id_r <= backend_id;
            weight_r <= weight;
            ok_r <= resolve_ok;
            pool_ok <= pool_ready;
            found <= 1'b0;
            fslot <= '0;
            total <= '0;
            cnt <= '0;
            if (!pool_ready || cmd > CMD_QUERY) begin
              state <= S_WRITE;
            end else begin
              state <= S_SCAN1;
            end
          end
        end
        S_SCAN1: begin
          cnt <= cnt + 1'b1;
          if (eval) begin
            if (cmd_r == CMD_SELECT) begin
              if (e_active) begin
                total <= total + TW'(sw);
              end
            end else if (cmd_r == CMD_ADD) begin
              if (!rdata.used && !found) begin
                found <= 1'b1;
                fslot <= pidx;
              end
            end else if (rdata.used && rdata.ident == id_r && !found) begin
              found <= 1'b1;
              fslot <= pidx;
              fent <= rdata;
            end
          end
          if (cnt == CW'(SLOT_COUNT)) begin
            cnt <= '0;
            div_sh <= rr_counter;
            div_cnt <= '0;
            rem <= '0;
            if (cmd_r == CMD_SELECT) begin
              state <= S_DIV;
            end else begin
              state <= S_WRITE;
            end
          end
        end
        S_DIV: begin
          if (total == '0) begin
            state <= S_WRITE;
          end else begin
            rem <= rem_next;
            div_sh <= {div_sh[RR_W-2:0], 1'b0};
            div_cnt <= div_cnt + 1'b1;
            if (div_cnt == DCW'(RR_W - 1)) begin
              rr_counter <= rr_counter + 1'b1;
              state <= S_SCAN2;
            end
          end
        end
        S_SCAN2: begin
          cnt <= cnt + 1'b1;
          if (eval && e_active && !found) begin
            if (rem < TW'(sw)) begin
              found <= 1'b1;
              fslot <= pidx;
              fent <= rdata;
            end else begin
              rem <= rem - TW'(sw);
            end
          end
          if (cnt == CW'(SLOT_COUNT)) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status <= st_next;
            result_id <= rid_next;
            result_slot <= (st_next == ST_OK && rid_next != 32'd0) || (st_next == ST_OK &&
                           found && (cmd_r == CMD_ADD || cmd_r == CMD_SELECT)) ?
                           slot_wide[5:0] : 6'd0;
            in_flight_count <= cnt_out_next;
            if (pool_ok && cmd_r == CMD_ADD && found) begin
              next_ident <= next_ident + 32'd1;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    (state == S_CLEAR) |-> !in_ready)
    else $error("input accepted during table clear");

  a_remainder_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN2 && cnt == '0) |-> (rem < total))
    else $error("remainder not below weight sum");

  a_select_finds: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && pool_ok && cmd_r == CMD_SELECT && total != '0) |-> found)
    else $error("select walked past all weight bands");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_NO_ACTIVE))
    else $error("status code out of range");

  a_ident_step: assert property (@(posedge clk) disable iff (rst)
    (state == S_WRITE && out_free && pool_ok && cmd_r == CMD_ADD && found)
      |=> (next_ident == $past(next_ident) + 32'd1))
    else $error("id counter did not advance on add");

endmodule
